// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared field widths, register indexes and side codes for the signal
// persistence qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // field widths of one input transaction
    localparam int CHAN_BITS   = 6;
    localparam int SIDE_BITS   = 2;
    localparam int TIME_BITS   = 48;
    localparam int MAX_CHANNEL = 64;

    // configuration register widths
    localparam int PERSIST_BITS = 48;
    localparam int CONFIRM_BITS = 16;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DATA_BITS = 48;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_BITS = 56;
    localparam int S_TUSER_BITS = 8;
    localparam int M_TDATA_BITS = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PERSIST = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CONFIRM = 8'd1;

    // side codes
    localparam logic [SIDE_BITS-1:0] SIDE_HOLD = 2'd0;

endpackage

`default_nettype wire

// ===== design/signal_persistence_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// signal_persistence_qualifier_core
// Per-channel persistence and confirmation filter for directional signals.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  -------------------------------------
//  s_axis    in   tvalid / tready        tdata: channel, time_ms; tuser: flags
//  m_axis    out  tvalid / tready        tdata: allow
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  One transaction per cycle is accepted while m_axis does not stall; its result
//  passes the input/read register, then the result register.
//  Candidate side, first time and count sit in a NUM_CHANNELS-deep memory,
//  capped at MAX_CHANNEL, with a registered read port; the item ahead's write
//  is bypassed into the next item, so back-to-back hits on one channel see
//  current state. Active bits are flip-flops cleared by reset; no clearing
//  pass is needed. A stall on m_axis holds the result register and the
//  processing stage, and s_axis tready drops once the processing stage is
//  full, until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module signal_persistence_qualifier_core #(
    parameter int NUM_CHANNELS = 64,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // [5:0] channel, [53:6] time_ms, [55:54] zero
    input  wire logic [spq_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    // [0] sig_valid, [2:1] sig_side, [7:3] zero
    input  wire logic [spq_pkg::S_TUSER_BITS-1:0]  s_axis_tuser,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [0] allow, [7:1] zero
    output logic [spq_pkg::M_TDATA_BITS-1:0]       m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [spq_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [spq_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int DEPTH  = (NUM_CHANNELS < spq_pkg::MAX_CHANNEL) ?
                            NUM_CHANNELS : spq_pkg::MAX_CHANNEL;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (COUNT_BITS > spq_pkg::CONFIRM_BITS) ?
                            COUNT_BITS : spq_pkg::CONFIRM_BITS;

    typedef struct packed {
        logic [COUNT_BITS-1:0]           count;
        logic [spq_pkg::TIME_BITS-1:0]   first_ms;
        logic [spq_pkg::SIDE_BITS-1:0]   side;
    } t_cand;

    // configuration registers
    logic [spq_pkg::PERSIST_BITS-1:0] r_min_persist;
    logic [spq_pkg::CONFIRM_BITS-1:0] r_min_confirm;

    // processing stage
    logic                            r_s1_valid;
    logic [spq_pkg::CHAN_BITS-1:0]   r_ch;
    logic                            r_sig_valid;
    logic [spq_pkg::SIDE_BITS-1:0]   r_side;
    logic [spq_pkg::TIME_BITS-1:0]   r_time;
    t_cand                           r_rd;
    logic                            r_byp;
    t_cand                           r_byp_data;

    // candidate state
    logic [DEPTH-1:0]                r_active;
    t_cand                           r_mem [DEPTH];

    // result register
    logic                            r_out_valid;
    logic                            r_out_allow;

    // stage logic
    logic                            s_acc;
    logic                            s1_go;
    logic [spq_pkg::CHAN_BITS-1:0]   in_ch;
    logic [ADDR_W-1:0]               in_addr;
    logic [ADDR_W-1:0]               s1_addr;
    logic                            s1_in_rng;
    logic                            s1_dir;
    logic                            s1_act;
    logic                            s1_same;
    t_cand                           s1_cur;
    logic [COUNT_BITS-1:0]           s1_cnt_inc;
    logic [spq_pkg::TIME_BITS:0]     s1_diff;
    logic                            s1_time_ok;
    logic                            s1_cnt_ok;
    logic                            s1_allow;
    logic                            s1_wr;
    t_cand                           s1_wd;

    assign o_cfg_ready   = 1'b1;
    assign s1_go         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_ch         = s_axis_tdata[spq_pkg::CHAN_BITS-1:0];
    assign in_addr       = in_ch[ADDR_W-1:0];
    assign s1_addr       = r_ch[ADDR_W-1:0];

    // evaluate the item held in the processing stage
    always_comb begin
        s1_in_rng  = (32'(r_ch) < NUM_CHANNELS);
        s1_dir     = r_sig_valid && (r_side != spq_pkg::SIDE_HOLD);
        s1_act     = s1_in_rng ? r_active[s1_addr] : 1'b0;
        s1_cur     = r_byp ? r_byp_data : r_rd;
        s1_same    = s1_act && (s1_cur.side == r_side);
        s1_cnt_inc = (s1_cur.count == {COUNT_BITS{1'b1}}) ? s1_cur.count :
                     COUNT_BITS'(s1_cur.count + COUNT_BITS'(1));
        s1_diff    = {1'b0, r_time} - {1'b0, s1_cur.first_ms};
        s1_time_ok = !s1_diff[spq_pkg::TIME_BITS] &&
                     (s1_diff[spq_pkg::TIME_BITS-1:0] >= r_min_persist);
        s1_cnt_ok  = (CMP_W'(s1_cnt_inc) >= CMP_W'(r_min_confirm));
        s1_allow   = s1_in_rng && s1_dir && s1_same && s1_time_ok && s1_cnt_ok;
        s1_wr      = s1_in_rng && s1_dir;
        if (s1_same) begin
            s1_wd = '{count: s1_cnt_inc, first_ms: s1_cur.first_ms, side: r_side};
        end else begin
            s1_wd = '{count: COUNT_BITS'(1), first_ms: r_time, side: r_side};
        end
    end

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_persist <= '0;
            r_min_confirm <= spq_pkg::CONFIRM_BITS'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == spq_pkg::REG_MIN_PERSIST) begin
                r_min_persist <= i_cfg_data[spq_pkg::PERSIST_BITS-1:0];
            end else if (i_cfg_index == spq_pkg::REG_MIN_CONFIRM) begin
                r_min_confirm <= i_cfg_data[spq_pkg::CONFIRM_BITS-1:0];
            end
        end
    end

    // capture the input transaction and flag a bypass from the item ahead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s1_valid <= 1'b1;
                r_byp      <= s1_go && s1_wr && (r_ch == in_ch);
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_ch        <= in_ch;
            r_time      <= s_axis_tdata[spq_pkg::CHAN_BITS +: spq_pkg::TIME_BITS];
            r_sig_valid <= s_axis_tuser[0];
            r_side      <= s_axis_tuser[1 +: spq_pkg::SIDE_BITS];
            r_byp_data  <= s1_wd;
        end
    end

    // candidate memory: registered read on accept, write as the item leaves
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_rd <= r_mem[in_addr];
        end
        if (s1_go && s1_wr) begin
            r_mem[s1_addr] <= s1_wd;
        end
    end

    // update active bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (s1_go && s1_in_rng) begin
            r_active[s1_addr] <= s1_dir && !s1_allow;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_allow <= s1_allow;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(spq_pkg::M_TDATA_BITS-1){1'b0}}, r_out_allow};

    // an allow decision lands in the result register
    a_allow_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && s1_allow |=> r_out_valid && r_out_allow)
        else $error("allow decision lost on the way to the result register");

    // only an active candidate can allow
    a_allow_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s1_allow |-> s1_act && s1_same)
        else $error("allow without an active same-side candidate");

    // an empty processing stage always takes input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> s_axis_tready)
        else $error("input stalled with an empty processing stage");

endmodule

`default_nettype wire
